[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/bmpw_pkg.sv]
// types, constants and header byte function of the bmp stream writer
package bmpw_pkg;

	localparam int unsigned MAX_DIM    = 8192;
	localparam int unsigned DIM_W      = 14;
	localparam int unsigned CNT_W      = 13;
	localparam int unsigned PROD_W     = 28;
	localparam int unsigned HDR_BYTES  = 54;
	localparam int unsigned INFO_BYTES = 40;
	localparam int unsigned BITS_PIX   = 24;
	localparam int unsigned QDEPTH     = 2;

	localparam logic [5:0] HDR_LAST = 6'(HDR_BYTES - 1);
	localparam logic [7:0] SIG_B    = 8'h42;
	localparam logic [7:0] SIG_M    = 8'h4D;

	// config register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// one classified pixel waiting for the back end
	typedef struct packed {
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
		logic              hdr;
		logic              image_end;
		logic [1:0]        pad;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [PROD_W-1:0] prod;
	} bmpw_entry_t;

	typedef struct packed {
		logic valid;
		logic full;
	} bmpw_qstat_t;

	// byte idx of the 54-byte header
	function automatic logic [7:0] hdr_byte(input logic [5:0] idx,
		input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
		input logic [PROD_W-1:0] prod);
		logic [31:0] size;
		logic [31:0] wid;
		logic [31:0] neg_h;
		logic [7:0]  b;
		size  = 32'(prod) + 32'(HDR_BYTES);
		wid   = 32'(w);
		neg_h = 32'd0 - 32'(h);
		case (idx)
			6'd0:  b = SIG_B;
			6'd1:  b = SIG_M;
			6'd2:  b = size[7:0];
			6'd3:  b = size[15:8];
			6'd4:  b = size[23:16];
			6'd5:  b = size[31:24];
			6'd10: b = 8'(HDR_BYTES);
			6'd14: b = 8'(INFO_BYTES);
			6'd18: b = wid[7:0];
			6'd19: b = wid[15:8];
			6'd20: b = wid[23:16];
			6'd21: b = wid[31:24];
			6'd22: b = neg_h[7:0];
			6'd23: b = neg_h[15:8];
			6'd24: b = neg_h[23:16];
			6'd25: b = neg_h[31:24];
			6'd26: b = 8'd1;
			6'd28: b = 8'(BITS_PIX);
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

[hw/rtl/bmpw_front.sv]
// front end: config registers, pixel position counters and item classification
module bmpw_front import bmpw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  bmpw_qstat_t       qstat,
	output logic              push,
	output bmpw_entry_t       entry
);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [CNT_W-1:0]  col_q;
	logic [CNT_W-1:0]  row_q;
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [1:0]        full_pad;
	logic [DIM_W:0]    row_bytes;
	logic              row_end;
	logic              image_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_eff = DIM_W'(1);
		else if (width_q > DIM_W'(MAX_DIM))
			w_eff = DIM_W'(MAX_DIM);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = DIM_W'(1);
		else if (height_q > DIM_W'(MAX_DIM))
			h_eff = DIM_W'(MAX_DIM);
		else
			h_eff = height_q;
	end

	// pad = (-3w) mod 4
	assign full_pad  = 2'd0 - 2'(w_eff[1:0] * 2'd3);
	assign row_bytes = (DIM_W+1)'(w_eff) * (DIM_W+1)'(3) + (DIM_W+1)'(full_pad);
	assign row_end   = ({1'b0, col_q} + DIM_W'(1)) >= w_eff;
	assign image_end = row_end && (({1'b0, row_q} + DIM_W'(1)) >= h_eff);

	assign push = in_valid && !qstat.full;

	always_comb begin
		entry.red       = red;
		entry.green     = green;
		entry.blue      = blue;
		entry.hdr       = (col_q == '0) && (row_q == '0);
		entry.image_end = image_end;
		entry.pad       = row_end ? full_pad : 2'd0;
		entry.width     = w_eff;
		entry.height    = h_eff;
		entry.prod      = PROD_W'(row_bytes) * PROD_W'(h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= image_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/bmpw_queue.sv]
// short item queue between front and back end
module bmpw_queue import bmpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bmpw_entry_t wr_entry,
	input  logic        pop,
	output bmpw_entry_t head,
	output bmpw_qstat_t qstat
);

	localparam int unsigned PTR_W = $clog2(QDEPTH);

	bmpw_entry_t        mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (PTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PTR_W+1)'(1);
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.valid = count_q != '0;
	assign qstat.full  = count_q == (PTR_W+1)'(QDEPTH);

endmodule

[hw/rtl/bmpw_back.sv]
// back end: byte sequencer and output register
module bmpw_back import bmpw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bmpw_entry_t head,
	input  bmpw_qstat_t qstat,
	output logic        pop,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        image_done
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HDR  = 4'b0010,
		ST_PIX  = 4'b0100,
		ST_PAD  = 4'b1000
	} seq_st_t;

	seq_st_t     st_q, cur_st, nxt_st;
	logic [5:0]  cnt_q, cur_cnt, nxt_cnt;
	logic        advance;
	logic        emit;
	logic        final_b;
	logic [7:0]  byte_d;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        done_q;

	assign advance = !out_valid_q || !out_stall;
	assign emit    = advance && qstat.valid;

	always_comb begin
		if (st_q == ST_IDLE) begin
			cur_st  = head.hdr ? ST_HDR : ST_PIX;
			cur_cnt = '0;
		end else begin
			cur_st  = st_q;
			cur_cnt = cnt_q;
		end
		byte_d  = 8'd0;
		final_b = 1'b0;
		nxt_st  = cur_st;
		nxt_cnt = cur_cnt + 6'd1;
		case (cur_st)
			ST_HDR: begin
				byte_d = hdr_byte(cur_cnt, head.width, head.height, head.prod);
				if (cur_cnt == HDR_LAST) begin
					nxt_st  = ST_PIX;
					nxt_cnt = '0;
				end
			end
			ST_PIX: begin
				case (cur_cnt[1:0])
					2'd0:    byte_d = head.blue;
					2'd1:    byte_d = head.green;
					default: byte_d = head.red;
				endcase
				if (cur_cnt[1:0] == 2'd2) begin
					nxt_cnt = '0;
					if (head.pad == 2'd0) begin
						final_b = 1'b1;
						nxt_st  = ST_IDLE;
					end else begin
						nxt_st = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (cur_cnt[1:0] == head.pad - 2'd1) begin
					final_b = 1'b1;
					nxt_st  = ST_IDLE;
					nxt_cnt = '0;
				end
			end
			default: begin
				nxt_st  = ST_IDLE;
				nxt_cnt = '0;
			end
		endcase
	end

	assign pop = emit && final_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= qstat.valid;
			if (qstat.valid) begin
				st_q  <= nxt_st;
				cnt_q <= nxt_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_d;
			last_q     <= final_b;
			done_q     <= final_b && head.image_end;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign image_done  = done_q;

endmodule

[hw/rtl/bmp24_image_stream_writer_unit.sv]
// top level of the 24-bit top-down bmp stream writer
// usage:
// - input channel (in_valid/in_stall, red/green/blue) takes one pixel per item,
//   row-major, top row first
// - output channel (out_valid/out_stall, out_byte) gives the bmp file one byte
//   per item; last_of_run marks the final byte caused by a pixel, image_done the
//   final byte of the whole file
// - cfg_we/cfg_index/cfg_data write image_width (index 0) and image_height
//   (index 1); write only while no pixel is in flight
// - the first pixel of an image is preceded by the 54-byte header, each row
//   ends with zero padding up to a multiple of four bytes
// - with the queue empty, an accepted pixel passes through the queue and then
//   the output register before its first byte is valid
// - the byte sequencer gives one byte per cycle unless stalled or queue empty:
//   3 per pixel, plus 54 for the header pixel and up to 3 at a row end
// - a two-item queue decouples the front end, so pixels keep being taken while
//   the back end is still sending bytes
// - receiver stall holds the output register; the queue then fills and
//   in_stall rises
// - reset: dimensions return to 1, position counters and queue clear
`include "assert_macros.svh"

module bmp24_image_stream_writer_unit import bmpw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              last_of_run,
	output logic              image_done
);

	// front to queue
	logic         push;
	bmpw_entry_t  entry;

	// queue to back
	bmpw_entry_t  head;
	bmpw_qstat_t  qstat;
	logic         pop;

	// classify each pixel: header needed, row end, padding, file size product
	bmpw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.qstat     (qstat),
		.push      (push),
		.entry     (entry)
	);

	// stall the sender only when the queue is full
	assign in_stall = qstat.full;

	bmpw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (entry),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// turn each queued pixel into header, pixel and padding bytes
	bmpw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.image_done  (image_done)
	);

	// end of file is always also end of a pixel's bytes
	`ASSERT_SAME(a_done_is_last, clk, arst_n, out_valid && image_done, last_of_run)
	// a pop only happens with something in the queue
	`ASSERT_SAME(a_pop_has_item, clk, arst_n, pop, qstat.valid)
	// finishing a pixel always leaves a byte on the output
	`ASSERT_NEXT(a_pop_gives_byte, clk, arst_n, pop, out_valid && last_of_run)

endmodule

[sim/bmp24_image_stream_writer_unit_tb.sv]
// self-checking testbench for the 24-bit top-down bmp stream writer
module bmp24_image_stream_writer_unit_tb import bmpw_pkg::*; ;

	// run limits
	localparam int RANDOM_PIXELS = 410;
	localparam int LONG_HOLD     = 300;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 6;

	// one byte of the bmp file with its markers
	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       done;
	} file_byte_t;

	// tracks the writer's position and the file bytes still to come
	class bmp_stream_tracker;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		logic [CNT_W-1:0] column;
		logic [CNT_W-1:0] row;
		file_byte_t       bytes_due[$];
		int               mismatches;

		function new();
			width_reg  = 1;
			height_reg = 1;
			column     = 0;
			row        = 0;
			mismatches = 0;
		endfunction

		function void set_register(logic idx, logic [DIM_W-1:0] value);
			if (idx == REG_WIDTH) begin
				width_reg = value;
			end else begin
				height_reg = value;
			end
		endfunction

		// zero counts as one, oversize clamps to the maximum
		function int unsigned effective(logic [DIM_W-1:0] r);
			if (r == 0)
				return 1;
			if (r > MAX_DIM)
				return MAX_DIM;
			return r;
		endfunction

		function int pending();
			return bytes_due.size();
		endfunction

		function void push(logic [7:0] b, logic last, logic done);
			file_byte_t fb;
			fb.value = b;
			fb.last  = last;
			fb.done  = done;
			bytes_due.push_back(fb);
		endfunction

		// little-endian field of n bytes
		function void push_le(logic [31:0] v, int n);
			for (int k = 0; k < n; k++)
				push(v[8*k +: 8], 1'b0, 1'b0);
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int unsigned w;
			int unsigned h;
			int unsigned pad;
			logic [31:0] size;
			bit          row_end;
			bit          image_end;
			w         = effective(width_reg);
			h         = effective(height_reg);
			pad       = (4 - ((w * 3) & 3)) & 3;
			row_end   = (int'(column) + 1) >= w;
			image_end = row_end && ((int'(row) + 1) >= h);
			if (column == 0 && row == 0) begin
				size = 32'(HDR_BYTES) + 32'(h) * (32'(w) * 3 + 32'(pad));
				push("B", 1'b0, 1'b0);
				push("M", 1'b0, 1'b0);
				push_le(size, 4);
				push_le(0, 4);
				push_le(HDR_BYTES, 4);
				push_le(INFO_BYTES, 4);
				push_le(w, 4);
				push_le(32'd0 - 32'(h), 4);
				push_le(1, 2);
				push_le(BITS_PIX, 2);
				for (int k = 0; k < 6; k++)
					push_le(0, 4);
			end
			// blue, green, red order in the file
			push(b, 1'b0, 1'b0);
			push(g, 1'b0, 1'b0);
			push(r, !row_end || pad == 0, image_end && pad == 0);
			if (row_end) begin
				for (int k = 0; k < pad; k++)
					push(8'h00, k == pad - 1, image_end && k == pad - 1);
				column = 0;
				row    = image_end ? '0 : row + 1'b1;
			end else begin
				column = column + 1'b1;
			end
		endfunction

		function void check_byte(logic [7:0] b, logic last, logic done);
			file_byte_t want;
			if (bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("byte %h last %b done %b arrived with nothing due", b, last, done);
				return;
			end
			want = bytes_due.pop_front();
			if (want.value !== b || want.last !== last || want.done !== done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected byte %h last %b done %b, got byte %h last %b done %b",
						want.value, want.last, want.done, b, last, done);
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic             cfg_index = REG_WIDTH;
	logic [DIM_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	logic [7:0]       red       = 8'h00;
	logic [7:0]       green     = 8'h00;
	logic [7:0]       blue      = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       out_byte;
	logic             last_of_run;
	logic             image_done;

	bmp_stream_tracker tracker = new();

	// receiver pattern and long hold bookkeeping
	int hold_asked   = 0;
	int hold_served  = 0;
	int hold_left    = 0;
	int pattern_left = 0;
	int stall_pct    = 0;
	int quiet_cycles = 0;

	bmp24_image_stream_writer_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.image_done  (image_done)
	);

	always #2 clk = ~clk;

	// monitor: all samples are pre-edge values, every drive is nonblocking
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				tracker.set_register(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				tracker.note_pixel(red, green, blue);
			if (out_valid && !out_stall)
				tracker.check_byte(out_byte, last_of_run, image_done);
		end
		// no handshake on either side counts toward the watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// receiver: a long hold on request, otherwise stretches of varying stall density
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left   <= LONG_HOLD;
			out_stall   <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				pattern_left <= $urandom_range(100, 20);
				case ($urandom_range(2))
					0: stall_pct <= 0;
					1: stall_pct <= 15;
					default: stall_pct <= 60;
				endcase
			end else begin
				pattern_left <= pattern_left - 1;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog: nothing moving for too long means a hang
	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// offer one pixel and hold it until taken
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		red      <= r;
		green    <= g;
		blue     <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause_sender(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// stop sending, let every due byte come out, then let the output settle
	task automatic wait_file_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// writes both dimension registers, only while the writer is idle
	task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// random pixels, in bursts with random gaps when asked
	task automatic run_pixels(input int count, input bit with_gaps);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (with_gaps && burst == 0) begin
				burst = $urandom_range(12, 1);
				if ($urandom_range(3) != 0)
					pause_sender($urandom_range(8, 1));
			end
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			if (burst != 0)
				burst--;
		end
	endtask

	initial begin
		int sent;
		int count;
		int unsigned ew;
		int unsigned eh;
		logic [DIM_W-1:0] w_val;
		logic [DIM_W-1:0] h_val;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset dimensions 1x1: header on every pixel, one pad byte per row
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		wait_file_drained();

		// zero dimensions behave as one
		set_dims(0, 0);
		send_pixel(8'hff, 8'h00, 8'hff);
		send_pixel(8'h00, 8'hff, 8'h00);
		wait_file_drained();

		// 3x2: three pad bytes per row
		set_dims(3, 2);
		send_pixel(8'h80, 8'h7f, 8'h01);
		send_pixel(8'h01, 8'h80, 8'h7f);
		send_pixel(8'h7f, 8'h01, 8'h80);
		send_pixel(8'haa, 8'h55, 8'hc3);
		send_pixel(8'h55, 8'hc3, 8'haa);
		send_pixel(8'hc3, 8'haa, 8'h55);
		wait_file_drained();

		// 4x1: rows already a multiple of four
		set_dims(4, 1);
		send_pixel(8'h10, 8'h20, 8'h30);
		send_pixel(8'hf0, 8'he0, 8'hd0);
		send_pixel(8'h0f, 8'h0e, 8'h0d);
		send_pixel(8'hfe, 8'hfd, 8'hfc);
		wait_file_drained();

		// oversize registers clamp, then shrinking mid-image closes it at once
		set_dims(14'h3fff, 14'h3fff);
		send_pixel(8'h12, 8'h34, 8'h56);
		send_pixel(8'h9a, 8'hbc, 8'hde);
		wait_file_drained();
		set_dims(1, 1);
		send_pixel(8'h21, 8'h43, 8'h65);
		wait_file_drained();

		// exact maximum, then end a row and the image by shrinking in two steps
		set_dims(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
		send_pixel(8'h01, 8'h02, 8'h04);
		wait_file_drained();
		set_dims(1, DIM_W'(MAX_DIM));
		send_pixel(8'h08, 8'h10, 8'h20);
		wait_file_drained();
		set_dims(1, 1);
		send_pixel(8'h40, 8'h80, 8'hff);
		wait_file_drained();

		// back-pressure: receiver holds off while pixels keep coming with no gaps
		set_dims(5, 3);
		hold_asked <= hold_asked + 1;
		run_pixels(45, 1'b0);
		wait_file_drained();
		sent = 45;

		// random phases: mostly small whole images, some partial, some odd sizes
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(11))
				0: w_val = 0;
				1: w_val = DIM_W'($urandom_range(16383, MAX_DIM));
				default: w_val = DIM_W'($urandom_range(10, 1));
			endcase
			case ($urandom_range(11))
				0: h_val = 0;
				1: h_val = DIM_W'($urandom_range(16383, MAX_DIM));
				default: h_val = DIM_W'($urandom_range(4, 1));
			endcase
			ew = tracker.effective(w_val);
			eh = tracker.effective(h_val);
			if (ew * eh <= 40)
				count = ew * eh * $urandom_range(2, 1);
			else
				count = $urandom_range(6, 1);
			// leave the image unfinished now and then
			if ($urandom_range(3) == 0)
				count += $urandom_range(4, 1);
			set_dims(w_val, h_val);
			run_pixels(count, $urandom_range(3) != 0);
			wait_file_drained();
			sent += count;
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
